[design/sha256_pkg.sv]
// Shared types, codes and constants for the SHA-256 stream hasher.
// Holds the round constant table, initial hash value and round functions.
// No dependencies.
package sha256_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int BLOCK_BYTES = 64;
    localparam int HASH_WORDS  = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word IV [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h00000000;
        endcase
        return k;
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

[design/sha256_stream_hasher_top.sv]
// SHA-256 stream hasher: byte-wide absorb, one round per cycle on a shared round unit.
// Absorb: bytes are taken while idle; the 64th byte of a block starts its compression.
// Finish: 0x80 and zero pad to byte 56 (a block without room is compressed first), then
// the 64-bit bit length, compression, and eight digest words, one per unstalled cycle.
// Depends on sha256_pkg for state codes, round constants and round functions.
// Synchronous active-low reset loads the initial hash value and clears counts.
module sha256_stream_hasher_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_state r_state, n_state;
    sha256_pkg::t_state r_ret, n_ret;

    sha256_pkg::t_word r_hash [sha256_pkg::HASH_WORDS];
    sha256_pkg::t_word n_hash [sha256_pkg::HASH_WORDS];
    sha256_pkg::t_word r_v    [sha256_pkg::HASH_WORDS];
    sha256_pkg::t_word n_v    [sha256_pkg::HASH_WORDS];

    logic [511:0] r_line, n_line;
    logic [5:0]   r_cnt, n_cnt;
    logic [5:0]   r_round, n_round;
    logic [63:0]  r_msg_bits, n_msg_bits;
    logic [63:0]  r_len, n_len;
    logic         r_first, n_first;
    logic [2:0]   r_idx, n_idx;

    logic         in_acc;
    logic         out_acc;
    sha256_pkg::t_word w0, w1, w9, w14, w_next, t1, t2;
    logic [7:0]   pad_byte;

    assign o_stall       = (r_state != sha256_pkg::ST_IDLE);
    assign o_valid       = (r_state == sha256_pkg::ST_OUT);
    assign o_digest_word = r_hash[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == 3'd7);

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign w0  = r_line[511:480];
    assign w1  = r_line[479:448];
    assign w9  = r_line[223:192];
    assign w14 = r_line[63:32];
    assign w_next = sha256_pkg::small_sigma1(w14) + w9 + sha256_pkg::small_sigma0(w1) + w0;

    assign t1 = r_v[7] + sha256_pkg::big_sigma1(r_v[4])
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
              + sha256_pkg::round_k(r_round) + w0;
    assign t2 = sha256_pkg::big_sigma0(r_v[0])
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));

    assign pad_byte = r_first ? 8'h80 : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha256_pkg::ST_IDLE;
            r_ret      <= sha256_pkg::ST_IDLE;
            r_hash     <= sha256_pkg::IV;
            r_cnt      <= '0;
            r_round    <= '0;
            r_msg_bits <= '0;
            r_first    <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_hash     <= n_hash;
            r_cnt      <= n_cnt;
            r_round    <= n_round;
            r_msg_bits <= n_msg_bits;
            r_first    <= n_first;
            r_idx      <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_line <= n_line;
        r_len  <= n_len;
        r_v    <= n_v;
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_hash     = r_hash;
        n_v        = r_v;
        n_line     = r_line;
        n_cnt      = r_cnt;
        n_round    = r_round;
        n_msg_bits = r_msg_bits;
        n_len      = r_len;
        n_first    = r_first;
        n_idx      = r_idx;
        case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_op == sha256_pkg::OP_ABSORB) begin
                        n_line = {r_line[503:0], i_data_byte};
                        n_cnt  = r_cnt + 6'd1;
                        if (r_cnt == 6'd63) begin
                            n_msg_bits = r_msg_bits + 64'd512;
                            n_v        = r_hash;
                            n_round    = '0;
                            n_ret      = sha256_pkg::ST_IDLE;
                            n_state    = sha256_pkg::ST_COMP;
                        end
                    end else begin
                        n_len   = r_msg_bits + {55'd0, r_cnt, 3'b000};
                        n_first = 1'b1;
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                n_line  = {r_line[503:0], pad_byte};
                n_first = 1'b0;
                n_cnt   = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_v     = r_hash;
                    n_round = '0;
                    n_ret   = sha256_pkg::ST_PAD;
                    n_state = sha256_pkg::ST_COMP;
                end else if (r_cnt == 6'd55) begin
                    n_state = sha256_pkg::ST_LEN;
                end
            end
            sha256_pkg::ST_LEN: begin
                n_line = {r_line[503:0], r_len[63:56]};
                n_len  = {r_len[55:0], 8'h00};
                n_cnt  = r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    n_v     = r_hash;
                    n_round = '0;
                    n_ret   = sha256_pkg::ST_OUT;
                    n_state = sha256_pkg::ST_COMP;
                end
            end
            sha256_pkg::ST_COMP: begin
                n_line  = {r_line[479:0], w_next};
                n_v[7]  = r_v[6];
                n_v[6]  = r_v[5];
                n_v[5]  = r_v[4];
                n_v[4]  = r_v[3] + t1;
                n_v[3]  = r_v[2];
                n_v[2]  = r_v[1];
                n_v[1]  = r_v[0];
                n_v[0]  = t1 + t2;
                n_round = r_round + 6'd1;
                if (r_round == 6'd63) begin
                    n_state = sha256_pkg::ST_ADD;
                end
            end
            sha256_pkg::ST_ADD: begin
                for (int i = 0; i < sha256_pkg::HASH_WORDS; i++) begin
                    n_hash[i] = r_hash[i] + r_v[i];
                end
                n_idx   = '0;
                n_state = r_ret;
            end
            sha256_pkg::ST_OUT: begin
                if (!i_stall) begin
                    if (r_idx == 3'd7) begin
                        n_hash     = sha256_pkg::IV;
                        n_cnt      = '0;
                        n_msg_bits = '0;
                        n_idx      = '0;
                        n_state    = sha256_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = sha256_pkg::ST_IDLE;
            end
        endcase
    end

    a_block_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_COMP || r_state == sha256_pkg::ST_ADD) |-> (r_cnt == 6'd0))
        else $error("pending count not wrapped during compression");

    a_len_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::ST_LEN) |-> (r_cnt >= 6'd56))
        else $error("length bytes outside block tail");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && o_last_word) |=>
            (r_state == sha256_pkg::ST_IDLE && r_msg_bits == 64'd0 &&
             r_hash[0] == sha256_pkg::IV[0] && r_cnt == 6'd0))
        else $error("state not restored after digest");

    a_first_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_word_index == 3'd0))
        else $error("digest does not start at word zero");

endmodule

[tb/tb_sha256_stream_hasher_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sha256_stream_hasher_top: directed messages, then random ones.
// Depends on sha256_pkg for the operation codes; digest words are predicted locally.
module tb_sha256_stream_hasher_top;

    typedef struct packed {
        logic [31:0] dword;
        logic [2:0]  widx;
        logic        last;
    } t_digest_rec;

    typedef struct packed {
        logic         op;
        logic [7:0]   b;
        logic         typed;
        logic [255:0] dig;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_RANDOM,
        RX_TOGGLE
    } t_rx_mode;

    localparam logic [255:0] EMPTY_DIG =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIG =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    localparam int N_DIR       = 12;
    localparam int RAND_ITEMS  = 370;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 300;

    localparam t_dir_row DIR_TAB [N_DIR] = '{
        '{sha256_pkg::OP_FINISH, 8'h00, 1'b1, EMPTY_DIG},
        '{sha256_pkg::OP_ABSORB, 8'h61, 1'b0, 256'h0},
        '{sha256_pkg::OP_ABSORB, 8'h62, 1'b0, 256'h0},
        '{sha256_pkg::OP_ABSORB, 8'h63, 1'b0, 256'h0},
        '{sha256_pkg::OP_FINISH, 8'h00, 1'b1, ABC_DIG},
        '{sha256_pkg::OP_ABSORB, 8'h00, 1'b0, 256'h0},
        '{sha256_pkg::OP_ABSORB, 8'hff, 1'b0, 256'h0},
        '{sha256_pkg::OP_FINISH, 8'hff, 1'b0, 256'h0},
        '{sha256_pkg::OP_ABSORB, 8'haa, 1'b0, 256'h0},
        '{sha256_pkg::OP_ABSORB, 8'h55, 1'b0, 256'h0},
        '{sha256_pkg::OP_FINISH, 8'ha5, 1'b0, 256'h0},
        '{sha256_pkg::OP_FINISH, 8'h00, 1'b1, EMPTY_DIG}
    };

    localparam logic [31:0] KTAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int EDGE_LENS [10] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 128};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = sha256_pkg::OP_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    logic [31:0] hash_st [8];
    logic [7:0]  blk_bytes [64];
    int unsigned fill_cnt;
    logic [63:0] done_bits;

    t_digest_rec expected_words [$];
    int          err_cnt = 0;
    int          burst_left = 0;
    bit          hold_req = 1'b0;

    sha256_stream_hasher_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_message();
        int t;
        for (t = 0; t < 8; t++) hash_st[t] = START_HASH[t];
        fill_cnt  = 0;
        done_bits = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, x2, x15, t1, t2;
        int t, r;
        for (t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (t = 0; t < 8; t++) v[t] = hash_st[t];
        for (r = 0; r < 64; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                x2  = w[(r - 2) & 15];
                x15 = w[(r - 15) & 15];
                wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(r - 7) & 15]
                   + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[r & 15];
                w[r & 15] = wt;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[r] + wt;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (t = 0; t < 8; t++) hash_st[t] = hash_st[t] + v[t];
    endfunction

    function automatic void predict_digest(input logic op, input logic [7:0] b,
                                           input logic typed, input logic [255:0] dig);
        logic [63:0] total;
        t_digest_rec rec;
        int i;
        if (op == sha256_pkg::OP_ABSORB) begin
            blk_bytes[fill_cnt] = b;
            fill_cnt++;
            if (fill_cnt == 64) begin
                compress_block();
                done_bits = done_bits + 64'd512;
                fill_cnt  = 0;
            end
            return;
        end
        total = done_bits + 64'(fill_cnt * 8);
        blk_bytes[fill_cnt] = 8'h80;
        for (i = fill_cnt + 1; i < 64; i++) blk_bytes[i] = 8'h00;
        if (fill_cnt >= 56) begin
            compress_block();
            for (i = 0; i < 56; i++) blk_bytes[i] = 8'h00;
        end
        for (i = 0; i < 8; i++) blk_bytes[63 - i] = total[8*i +: 8];
        compress_block();
        for (i = 0; i < 8; i++) begin
            rec.dword = typed ? dig[255 - 32*i -: 32] : hash_st[i];
            rec.widx  = 3'(i);
            rec.last  = (i == 7);
            expected_words.push_back(rec);
        end
        restart_message();
    endfunction

    task automatic put_item(input logic op, input logic [7:0] b,
                            input logic typed, input logic [255:0] dig);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        predict_digest(op, b, typed, dig);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid    <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    initial begin : stimulus
        int k, len, msg, n_items, waited;
        restart_message();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++)
            put_item(DIR_TAB[k].op, DIR_TAB[k].b, DIR_TAB[k].typed, DIR_TAB[k].dig);
        wait_drained();

        n_items = 0;
        msg = 0;
        while (n_items < RAND_ITEMS) begin
            case (msg)
                0: len = 55;
                1: len = 56;
                2: len = 63;
                3: len = 64;
                default: len = ($urandom_range(0, 2) == 0) ? EDGE_LENS[$urandom_range(0, 9)]
                                                          : $urandom_range(0, 70);
            endcase
            for (k = 0; k < len; k++) begin
                put_item(sha256_pkg::OP_ABSORB, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
                n_items++;
            end
            // hold the receiver across this digest while the next message waits on the input stall
            if (msg == 2) hold_req = 1'b1;
            put_item(sha256_pkg::OP_FINISH, 8'($urandom_range(0, 255)), 1'b0, 256'h0);
            n_items++;
            if (msg == 5) wait_drained();
            msg++;
        end
        i_valid <= 1'b0;

        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (expected_words.size() != 0) begin
            $error("%0d digest words never arrived", expected_words.size());
            err_cnt++;
        end
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    always @(negedge i_clk) begin : rx_stall
        static int       hold_cnt = 0;
        static int       span = 0;
        static t_rx_mode mode = RX_FREE;
        if (hold_cnt != 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else begin
            if (span == 0) begin
                mode = t_rx_mode'($urandom_range(0, 2));
                span = $urandom_range(20, 150);
            end
            span--;
            case (mode)
                RX_FREE:   i_stall <= 1'b0;
                RX_RANDOM: i_stall <= ($urandom_range(0, 2) == 0);
                default:   i_stall <= ~i_stall;
            endcase
        end
    end

    always @(posedge i_clk) begin : digest_check
        t_digest_rec exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected digest word %h index %0d", o_digest_word, o_word_index);
                err_cnt++;
            end else begin
                exp_r = expected_words.pop_front();
                if (o_digest_word !== exp_r.dword) begin
                    $error("digest_word: expected %h, got %h", exp_r.dword, o_digest_word);
                    err_cnt++;
                end
                if (o_word_index !== exp_r.widx) begin
                    $error("word_index: expected %0d, got %0d", exp_r.widx, o_word_index);
                    err_cnt++;
                end
                if (o_last_word !== exp_r.last) begin
                    $error("last_word: expected %b, got %b", exp_r.last, o_last_word);
                    err_cnt++;
                end
            end
        end
    end

endmodule
